FILE: design/cartridge_bank_mapper_with_irq_timer_defines.svh
// Assertion macros shared by the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TIMER_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TIMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/cbm_pkg.sv
// Types and constants of the cartridge bank mapper.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

   typedef enum logic [1:0] {
      KIND_WRITE     = 2'd0,
      KIND_TICK      = 2'd1,
      KIND_CPU_XLATE = 2'd2,
      KIND_PPU_XLATE = 2'd3
   } kind_type;

   localparam logic [3:0] REGION_LATCH0 = 4'h8;
   localparam logic [3:0] REGION_LATCH1 = 4'h9;
   localparam logic [3:0] REGION_LATCH2 = 4'hA;
   localparam logic [3:0] REGION_LATCH3 = 4'hB;
   localparam logic [3:0] REGION_ENABLE = 4'hC;
   localparam logic [3:0] REGION_ACK    = 4'hD;
   localparam logic [3:0] REGION_SELECT = 4'hE;
   localparam logic [3:0] REGION_BANK   = 4'hF;

   localparam logic [1:0] SUB_PRG_HIGH = 2'b00;
   localparam logic [1:0] SUB_NONE     = 2'b01;
   localparam logic [1:0] SUB_MIRROR   = 2'b10;
   localparam logic [1:0] SUB_CHR      = 2'b11;

   localparam logic [15:0] TIMER_MAX      = 16'hFFFF;
   localparam logic [7:0]  FIXED_TOP_BANK = 8'd31;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } req_item_type;

   typedef struct packed {
      logic       irq_line;
      logic [7:0] bank;
      logic       is_ram;
      logic       mirror_vertical;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       use_prg;
      logic       fixed_top;
      logic       is_ram;
      logic       irq;
      logic       mirror;
   } stage_type;

endpackage

`default_nettype wire

FILE: design/cartridge_bank_mapper_with_irq_timer.sv
// Top level of the cartridge bank mapper with its cycle-counting IRQ timer.
//
// The req_ channel carries one transaction per CPU write, CPU cycle tick or
// address translation; the rsp_ channel returns exactly one transaction for
// each, in order, holding the IRQ line and mirroring after that transaction
// and the selected bank for translations.
// Bank registers live in small synchronous memories that are written and read
// in the cycle a transaction is accepted; the registered read data is formed
// into the result and held in an output register; rsp_valid rises once the
// result has passed from the read-stage registers into the output register,
// and a receiver stall can hold it in the read stage meanwhile.
// Throughput is one transaction per clock while the receiver does not stall; the
// memory read port and the output register set that figure.
// A synchronous reset clears all control state and the entry valid bits, so
// every bank register reads as zero until written.
// When the receiver stalls, the output register holds its transaction and one
// more is held in the read stage; req_stall rises only when both are full.
`timescale 1ns / 1ps
`default_nettype none
`include "cartridge_bank_mapper_with_irq_timer_defines.svh"

module cartridge_bank_mapper_with_irq_timer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire cbm_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output cbm_pkg::rsp_item_type      rsp_item
);

   logic [3:0]  prg_lo_mem [4];
   logic        prg_hi_mem [4];
   logic [7:0]  chr_mem [8];
   logic [3:0]  prg_lo_vld_ff, prg_hi_vld_ff;
   logic [7:0]  chr_vld_ff;

   logic [3:0]  prg_select_ff, prg_select_in;
   logic        mirror_ff, mirror_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] reload_ff, reload_in;
   logic [2:0]  enable_ff, enable_in;
   logic        irq_ff, irq_in;

   logic        accept, s1_advance;
   logic        s1_valid_ff, o_valid_ff;
   cbm_pkg::stage_type    s1_ff, s1_in;
   cbm_pkg::rsp_item_type o_item_ff, s1_result;

   logic [3:0]  prg_lo_q_ff;
   logic        prg_hi_q_ff;
   logic [7:0]  chr_q_ff;
   logic        prg_lo_qv_ff, prg_hi_qv_ff, chr_qv_ff;

   logic        prg_lo_we, prg_hi_we, chr_we;
   logic [1:0]  prg_lo_wa, prg_hi_wa;
   logic [2:0]  chr_wa;
   logic [3:0]  region;
   logic [1:0]  prg_ra;
   logic [2:0]  chr_ra;

   assign s1_advance = !o_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;
   assign rsp_valid  = o_valid_ff;
   assign rsp_item   = o_item_ff;

   assign region        = req_item.addr[15:12];
   assign prg_lo_wa     = prg_select_ff[1:0] - 2'd1;
   assign prg_hi_wa     = req_item.addr[1:0];
   assign chr_wa        = req_item.addr[2:0];
   assign prg_ra        = req_item.addr[14:13];
   assign chr_ra        = req_item.addr[12:10];

   always_comb begin
      prg_select_in = prg_select_ff;
      mirror_in     = mirror_ff;
      count_in      = count_ff;
      reload_in     = reload_ff;
      enable_in     = enable_ff;
      irq_in        = irq_ff;
      prg_lo_we     = 1'b0;
      prg_hi_we     = 1'b0;
      chr_we        = 1'b0;
      if (accept) begin
         case (req_item.kind)
            cbm_pkg::KIND_WRITE: begin
               if (req_item.addr[15]) begin
                  case (region)
                     cbm_pkg::REGION_LATCH0: reload_in[3:0]   = req_item.data[3:0];
                     cbm_pkg::REGION_LATCH1: reload_in[7:4]   = req_item.data[3:0];
                     cbm_pkg::REGION_LATCH2: reload_in[11:8]  = req_item.data[3:0];
                     cbm_pkg::REGION_LATCH3: reload_in[15:12] = req_item.data[3:0];
                     cbm_pkg::REGION_ENABLE: begin
                        enable_in = req_item.data[2:0];
                        if (req_item.data[1]) begin
                           count_in = reload_ff;
                        end
                        irq_in = 1'b0;
                     end
                     cbm_pkg::REGION_ACK: begin
                        enable_in[1] = enable_ff[0];
                        irq_in       = 1'b0;
                     end
                     cbm_pkg::REGION_SELECT: prg_select_in = req_item.data[3:0];
                     default: begin
                        prg_lo_we = (prg_select_ff >= 4'd1) && (prg_select_ff <= 4'd4);
                        case (req_item.addr[11:10])
                           cbm_pkg::SUB_PRG_HIGH: prg_hi_we = 1'b1;
                           cbm_pkg::SUB_MIRROR:   mirror_in = req_item.data[0];
                           cbm_pkg::SUB_CHR:      chr_we    = 1'b1;
                           default: ;
                        endcase
                     end
                  endcase
               end
            end
            cbm_pkg::KIND_TICK: begin
               if (enable_ff[1]) begin
                  if (count_ff == cbm_pkg::TIMER_MAX) begin
                     count_in = reload_ff;
                     irq_in   = 1'b1;
                  end else begin
                     count_in = count_ff + 16'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_in.kind      = req_item.kind;
      s1_in.use_prg   = req_item.addr[15] && (req_item.addr[14:13] != 2'b11);
      s1_in.fixed_top = req_item.addr[15] && (req_item.addr[14:13] == 2'b11);
      s1_in.is_ram    = (req_item.kind == cbm_pkg::KIND_CPU_XLATE)
                        && (req_item.addr[15:13] == 3'b011);
      s1_in.irq       = irq_in;
      s1_in.mirror    = mirror_in;
   end

   always_comb begin
      s1_result.irq_line        = s1_ff.irq;
      s1_result.is_ram          = s1_ff.is_ram;
      s1_result.mirror_vertical = s1_ff.mirror;
      case (s1_ff.kind)
         cbm_pkg::KIND_CPU_XLATE: begin
            if (s1_ff.fixed_top) begin
               s1_result.bank = cbm_pkg::FIXED_TOP_BANK;
            end else if (s1_ff.use_prg) begin
               s1_result.bank = {3'b000, prg_hi_q_ff && prg_hi_qv_ff,
                                 prg_lo_qv_ff ? prg_lo_q_ff : 4'd0};
            end else begin
               s1_result.bank = 8'd0;
            end
         end
         cbm_pkg::KIND_PPU_XLATE: s1_result.bank = chr_qv_ff ? chr_q_ff : 8'd0;
         default:                 s1_result.bank = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (prg_lo_we) begin
         prg_lo_mem[prg_lo_wa] <= req_item.data[3:0];
      end
      if (prg_hi_we) begin
         prg_hi_mem[prg_hi_wa] <= req_item.data[4];
      end
      if (chr_we) begin
         chr_mem[chr_wa] <= req_item.data;
      end
      if (accept) begin
         prg_lo_q_ff <= prg_lo_mem[prg_ra];
         prg_hi_q_ff <= prg_hi_mem[prg_ra];
         chr_q_ff    <= chr_mem[chr_ra];
         s1_ff       <= s1_in;
      end
      if (s1_valid_ff && s1_advance) begin
         o_item_ff <= s1_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_lo_vld_ff <= 4'd0;
         prg_hi_vld_ff <= 4'd0;
         chr_vld_ff    <= 8'd0;
         prg_lo_qv_ff  <= 1'b0;
         prg_hi_qv_ff  <= 1'b0;
         chr_qv_ff     <= 1'b0;
         prg_select_ff <= 4'd0;
         mirror_ff     <= 1'b0;
         count_ff      <= 16'd0;
         reload_ff     <= 16'd0;
         enable_ff     <= 3'd0;
         irq_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else begin
         if (prg_lo_we) begin
            prg_lo_vld_ff[prg_lo_wa] <= 1'b1;
         end
         if (prg_hi_we) begin
            prg_hi_vld_ff[prg_hi_wa] <= 1'b1;
         end
         if (chr_we) begin
            chr_vld_ff[chr_wa] <= 1'b1;
         end
         if (accept) begin
            prg_lo_qv_ff <= prg_lo_vld_ff[prg_ra];
            prg_hi_qv_ff <= prg_hi_vld_ff[prg_ra];
            chr_qv_ff    <= chr_vld_ff[chr_ra];
         end
         prg_select_ff <= prg_select_in;
         mirror_ff     <= mirror_in;
         count_ff      <= count_in;
         reload_ff     <= reload_in;
         enable_ff     <= enable_in;
         irq_ff        <= irq_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && s1_advance) begin
            o_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   `CBM_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall,
      s1_valid_ff && o_valid_ff, "input stalled while a stage was free")

   `CBM_ASSERT_NEXT(a_wrap_raises_irq, clock, reset,
      accept && (req_item.kind == cbm_pkg::KIND_TICK) && enable_ff[1]
         && (count_ff == cbm_pkg::TIMER_MAX),
      irq_ff && (count_ff == $past(reload_ff)), "timer wrap did not raise the IRQ")

   `CBM_ASSERT_NEXT(a_ack_clears_irq, clock, reset,
      accept && (req_item.kind == cbm_pkg::KIND_WRITE) && req_item.addr[15]
         && ((region == cbm_pkg::REGION_ENABLE) || (region == cbm_pkg::REGION_ACK)),
      !irq_ff, "acknowledge did not clear the IRQ")

   `CBM_ASSERT_SAME(a_no_bank_for_updates, clock, reset,
      s1_valid_ff && ((s1_ff.kind == cbm_pkg::KIND_WRITE)
         || (s1_ff.kind == cbm_pkg::KIND_TICK)),
      (s1_result.bank == 8'd0) && !s1_result.is_ram,
      "write or tick transaction returned a bank")

endmodule

`default_nettype wire
